// File: rtl/trd_pkg.sv
// Shared types, constants and helpers for the TLS record deframer.
package trd_pkg;

    localparam logic [7:0] TYPE_CCS     = 8'h14;
    localparam logic [7:0] TYPE_ALERT   = 8'h15;
    localparam logic [7:0] TYPE_HS      = 8'h16;
    localparam logic [7:0] TYPE_APPDATA = 8'h17;

    localparam int HEADER_LEN = 5;
    localparam int HDR_IDX_W  = $clog2(HEADER_LEN);

    localparam logic [HDR_IDX_W-1:0] HDR_TYPE    = HDR_IDX_W'(0);
    localparam logic [HDR_IDX_W-1:0] HDR_VER_HI  = HDR_IDX_W'(1);
    localparam logic [HDR_IDX_W-1:0] HDR_VER_LO  = HDR_IDX_W'(2);
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI  = HDR_IDX_W'(3);

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_HS      = 2'd0;
    localparam kind_t KIND_CCS     = 2'd1;
    localparam kind_t KIND_APPDATA = 2'd2;
    localparam kind_t KIND_ALERT   = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_connection;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_present;
        logic       last_of_record;
        kind_t      record_kind;
        logic       status;
    } out_item_t;

    typedef struct packed {
        logic  ok;
        kind_t kind;
    } class_t;

    // Map a content-type byte to a record kind; alert is always allowed.
    function automatic class_t classify(input logic [7:0] t, input kind_t expected);
        class_t c;
        c.ok   = 1'b0;
        c.kind = KIND_HS;
        if (t == TYPE_ALERT) begin
            c.ok   = 1'b1;
            c.kind = KIND_ALERT;
        end
        else begin
            unique case (expected)
                KIND_HS:
                begin
                    c.kind = KIND_HS;
                    c.ok   = (t == TYPE_HS);
                end
                KIND_CCS:
                begin
                    c.kind = KIND_CCS;
                    c.ok   = (t == TYPE_CCS);
                end
                KIND_APPDATA:
                begin
                    c.kind = KIND_APPDATA;
                    c.ok   = (t == TYPE_APPDATA);
                end
                default:
                begin
                    c.ok = 1'b0;
                end
            endcase
        end
        return c;
    endfunction

endpackage

// File: rtl/trd_parser.sv
// Record header parser and payload tagger state machine.
module trd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  trd_pkg::in_item_t   item,
    input  trd_pkg::kind_t      expected_kind,
    output logic                res_valid,
    output trd_pkg::out_item_t  res
);

    trd_pkg::phase_t                   phase_reg, phase_next;
    logic [trd_pkg::HDR_IDX_W-1:0]     hdr_idx_reg, hdr_idx_next;
    trd_pkg::kind_t                    kind_reg, kind_next;
    logic [7:0]                        len_hi_reg, len_hi_next;
    logic [15:0]                       remain_reg, remain_next;

    trd_pkg::class_t                   cls;
    logic [15:0]                       rec_len;

    assign cls     = trd_pkg::classify(item.data_byte, expected_kind);
    assign rec_len = {len_hi_reg, item.data_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= trd_pkg::PH_HEADER;
            hdr_idx_reg <= '0;
            kind_reg    <= trd_pkg::KIND_HS;
            len_hi_reg  <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            kind_reg    <= kind_next;
            len_hi_reg  <= len_hi_next;
            remain_reg  <= remain_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        kind_next    = kind_reg;
        len_hi_next  = len_hi_reg;
        remain_next  = remain_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (fire)
        begin
            if (item.new_connection)
            begin
                phase_next   = trd_pkg::PH_HEADER;
                hdr_idx_next = '0;
                kind_next    = trd_pkg::KIND_HS;
                len_hi_next  = '0;
                remain_next  = '0;
            end
            else
            begin
                unique case (phase_reg)
                    trd_pkg::PH_HEADER:
                    begin
                        unique case (hdr_idx_reg)
                            trd_pkg::HDR_TYPE:
                            begin
                                if (!cls.ok)
                                begin
                                    phase_next   = trd_pkg::PH_HALTED;
                                    hdr_idx_next = '0;
                                    res_valid    = 1'b1;
                                    res.status   = 1'b1;
                                end
                                else
                                begin
                                    kind_next    = cls.kind;
                                    hdr_idx_next = trd_pkg::HDR_VER_HI;
                                end
                            end
                            trd_pkg::HDR_VER_HI, trd_pkg::HDR_VER_LO:
                            begin
                                hdr_idx_next = hdr_idx_reg + trd_pkg::HDR_IDX_W'(1);
                            end
                            trd_pkg::HDR_LEN_HI:
                            begin
                                len_hi_next  = item.data_byte;
                                hdr_idx_next = hdr_idx_reg + trd_pkg::HDR_IDX_W'(1);
                            end
                            default:
                            begin
                                // low length byte closes the header
                                hdr_idx_next = '0;
                                if (rec_len == 16'd0)
                                begin
                                    res_valid          = 1'b1;
                                    res.last_of_record = 1'b1;
                                    res.record_kind    = kind_reg;
                                end
                                else
                                begin
                                    remain_next = rec_len;
                                    phase_next  = trd_pkg::PH_PAYLOAD;
                                end
                            end
                        endcase
                    end
                    trd_pkg::PH_PAYLOAD:
                    begin
                        remain_next         = remain_reg - 16'd1;
                        res_valid           = 1'b1;
                        res.payload_byte    = item.data_byte;
                        res.payload_present = 1'b1;
                        res.record_kind     = kind_reg;
                        res.last_of_record  = (remain_next == 16'd0);
                        if (remain_next == 16'd0)
                        begin
                            phase_next = trd_pkg::PH_HEADER;
                        end
                    end
                    default:
                    begin
                        // halted: drop bytes until a new connection
                    end
                endcase
            end
        end
    end

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == trd_pkg::PH_HALTED) |-> !res_valid)
        else $error("result produced while halted");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status) |=> (phase_reg == trd_pkg::PH_HALTED))
        else $error("type error did not halt parser");

    a_last_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.payload_present && res.last_of_record)
            |=> (phase_reg == trd_pkg::PH_HEADER && hdr_idx_reg == '0))
        else $error("last payload byte did not return to header");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == trd_pkg::PH_PAYLOAD) |-> (remain_reg != 16'd0))
        else $error("payload phase with nothing remaining");

endmodule

// File: rtl/tls_record_deframer_core.sv
// Top level of the TLS record deframer: input register, parser, result register.
//
// Takes one stream byte per clock with no bubbles while out_stall is low: an
// accepted transaction is held in the input register, parsed from there once
// the output can advance and, if it yields a result, that result is presented
// from the result register. Header bytes yield nothing except a type error or a
// zero-length record marker; every payload byte yields one result. A stall on
// the output backs up into in_stall only once both registers hold a
// transaction. After a type error the parser drops all bytes until a
// transaction with new_connection set. expected_kind is written through the
// cfg port, which is always ready, and must only change while the block is idle.
module tls_record_deframer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  trd_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output trd_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  trd_pkg::kind_t      cfg_data
);

    logic                 in_valid_reg, in_valid_next;
    trd_pkg::in_item_t    in_item_reg;
    logic                 out_valid_reg, out_valid_next;
    trd_pkg::out_item_t   out_item_reg;
    trd_pkg::kind_t       expected_kind_reg;

    logic                 advance;
    logic                 fire;
    logic                 in_take;
    logic                 res_valid;
    trd_pkg::out_item_t   res;

    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = fire && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            expected_kind_reg <= trd_pkg::KIND_HS;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                expected_kind_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
        if (fire && res_valid)
        begin
            out_item_reg <= res;
        end
    end

    trd_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .item          (in_item_reg),
        .expected_kind (expected_kind_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

endmodule
